// ===== sv/tfon_pkg.sv =====
`default_nettype none
package tfon_pkg;

    // field widths
    localparam int COORD_WIDTH  = 24;
    localparam int NORMAL_WIDTH = 16;

    // edge differences, products and cross product
    localparam int DIF_W = COORD_WIDTH + 1;
    localparam int PRD_W = 2 * DIF_W;
    localparam int CRS_W = PRD_W + 1;

    // triple product split into a low and a high partial product per axis
    localparam int CLO_W = (CRS_W + 1) / 2;
    localparam int CHI_W = CRS_W - CLO_W;
    localparam int PLO_W = CLO_W + 1 + DIF_W;
    localparam int PHI_W = CHI_W + DIF_W;
    localparam int SLO_W = PLO_W + 2;
    localparam int SHI_W = PHI_W + 2;
    localparam int TRP_W = SHI_W + CLO_W + 1;

    // leading zero count over the ored magnitudes, in byte groups
    localparam int GRP_W = 8;
    localparam int NGRP  = (CRS_W + GRP_W - 1) / GRP_W;
    localparam int PAD_W = NGRP * GRP_W;
    localparam int LZ_W  = $clog2(PAD_W);
    localparam int GLZ_W = $clog2(GRP_W);

    // scaled magnitudes, sum of squares and root
    localparam int MAG_W = 30;
    localparam int SUM_W = 2 * MAG_W + 2;
    localparam int RT_W  = MAG_W + 1;
    localparam int SQR_W = RT_W + 4;

    // divide: quotient, divisor, remainder, numerator
    localparam int FRAC_W = NORMAL_WIDTH - 2;
    localparam int QUO_W  = NORMAL_WIDTH - 1;
    localparam int DVS_W  = RT_W + 1;
    localparam int DRM_W  = DVS_W + 1;
    localparam int NUM_W  = MAG_W + QUO_W + 1;
    localparam logic [QUO_W-1:0] NRM_LIM = QUO_W'(1) << FRAC_W;

    // stages ahead of the root unit
    localparam int NPRE = 9;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] p0_x;
        logic signed [COORD_WIDTH-1:0] p0_y;
        logic signed [COORD_WIDTH-1:0] p0_z;
        logic signed [COORD_WIDTH-1:0] p1_x;
        logic signed [COORD_WIDTH-1:0] p1_y;
        logic signed [COORD_WIDTH-1:0] p1_z;
        logic signed [COORD_WIDTH-1:0] p2_x;
        logic signed [COORD_WIDTH-1:0] p2_y;
        logic signed [COORD_WIDTH-1:0] p2_z;
        logic signed [COORD_WIDTH-1:0] opp_x;
        logic signed [COORD_WIDTH-1:0] opp_y;
        logic signed [COORD_WIDTH-1:0] opp_z;
    } t_in;

    typedef struct packed {
        logic signed [NORMAL_WIDTH-1:0] normal_x;
        logic signed [NORMAL_WIDTH-1:0] normal_y;
        logic signed [NORMAL_WIDTH-1:0] normal_z;
        logic                           degenerate;
    } t_out;

    // per-item flags that ride along the root and divide stages
    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } t_side;

    typedef logic [2:0][MAG_W-1:0] t_mag3;
    typedef logic [2:0][QUO_W-1:0] t_quo3;
    typedef logic [2:0][DVS_W-1:0] t_rem3;

endpackage
`default_nettype wire

// ===== sv/tfon_sqrt.sv =====
`default_nettype none
module tfon_sqrt
    import tfon_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [SUM_W-1:0] i_sum,
    input  t_mag3            i_mag,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [RT_W-1:0]  o_root,
    output t_mag3            o_mag,
    output t_side            o_side
);

    logic [RT_W-1:0]  r_v;
    logic [SQR_W-1:0] r_rem  [RT_W];
    logic [RT_W-1:0]  r_root [RT_W];
    logic [SUM_W-1:0] r_rad  [RT_W];
    t_mag3            r_mag  [RT_W];
    t_side            r_side [RT_W];

    logic [SQR_W-1:0] p_rem  [RT_W];
    logic [RT_W-1:0]  p_root [RT_W];
    logic [SUM_W-1:0] p_rad  [RT_W];
    t_mag3            p_mag  [RT_W];
    t_side            p_side [RT_W];

    logic [SQR_W-1:0] w_sh   [RT_W];
    logic [SQR_W-1:0] w_tr   [RT_W];
    logic [RT_W-1:0]  w_ge;
    logic [SQR_W-1:0] n_rem  [RT_W];
    logic [RT_W-1:0]  n_root [RT_W];
    logic [SUM_W-1:0] n_rad  [RT_W];

    // stage inputs: first stage from the ports, the rest from the stage before
    for (genvar k = 0; k < RT_W; k++) begin : g_src
        if (k == 0) begin : g_first
            assign p_rem[k]  = '0;
            assign p_root[k] = '0;
            assign p_rad[k]  = i_sum;
            assign p_mag[k]  = i_mag;
            assign p_side[k] = i_side;
        end else begin : g_next
            assign p_rem[k]  = r_rem[k-1];
            assign p_root[k] = r_root[k-1];
            assign p_rad[k]  = r_rad[k-1];
            assign p_mag[k]  = r_mag[k-1];
            assign p_side[k] = r_side[k-1];
        end
    end

    // one root bit per stage: bring down two radicand bits, try 4r+1
    always_comb begin
        for (int k = 0; k < RT_W; k++) begin
            w_sh[k]   = {p_rem[k][SQR_W-3:0], p_rad[k][SUM_W-1 -: 2]};
            w_tr[k]   = SQR_W'({p_root[k], 2'b01});
            w_ge[k]   = (w_sh[k] >= w_tr[k]);
            n_rem[k]  = w_ge[k] ? (w_sh[k] - w_tr[k]) : w_sh[k];
            n_root[k] = {p_root[k][RT_W-2:0], w_ge[k]};
            n_rad[k]  = p_rad[k] << 2;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[RT_W-2:0], i_valid};
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < RT_W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= n_rad[k];
                r_mag[k]  <= p_mag[k];
                r_side[k] <= p_side[k];
            end
        end
    end

    assign o_valid = r_v[RT_W-1];
    assign o_root  = r_root[RT_W-1];
    assign o_mag   = r_mag[RT_W-1];
    assign o_side  = r_side[RT_W-1];

endmodule
`default_nettype wire

// ===== sv/tfon_div.sv =====
`default_nettype none
module tfon_div
    import tfon_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [RT_W-1:0] i_root,
    input  t_mag3           i_mag,
    input  t_side           i_side,
    output logic            o_valid,
    output t_quo3           o_quo,
    output t_side           o_side
);

    // prep stage: numerator m*2^QUO_W + r, divisor 2r
    logic [NUM_W-1:0] w_num [3];
    logic             r0_v;
    t_rem3            r0_rem;
    t_quo3            r0_low;
    logic [DVS_W-1:0] r0_dvs;
    t_side            r0_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_num[i] = (NUM_W'(i_mag[i]) << QUO_W) + NUM_W'(i_root);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r0_rem[i] <= DVS_W'(w_num[i] >> QUO_W);
                r0_low[i] <= w_num[i][QUO_W-1:0];
            end
            r0_dvs  <= {i_root, 1'b0};
            r0_side <= i_side;
        end
    end

    // restoring divide, one quotient bit per stage, three lanes
    logic [QUO_W-1:0] r_v;
    t_rem3            r_rem  [QUO_W];
    t_quo3            r_low  [QUO_W];
    t_quo3            r_quo  [QUO_W];
    logic [DVS_W-1:0] r_dvs  [QUO_W];
    t_side            r_side [QUO_W];

    t_rem3            p_rem  [QUO_W];
    t_quo3            p_low  [QUO_W];
    t_quo3            p_quo  [QUO_W];
    logic [DVS_W-1:0] p_dvs  [QUO_W];
    t_side            p_side [QUO_W];

    logic [DRM_W-1:0] w_sh   [QUO_W][3];
    logic [DRM_W-1:0] w_dv   [QUO_W];
    logic [2:0]       w_ge   [QUO_W];
    t_rem3            n_rem  [QUO_W];
    t_quo3            n_low  [QUO_W];
    t_quo3            n_quo  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_src
        if (k == 0) begin : g_first
            assign p_rem[k]  = r0_rem;
            assign p_low[k]  = r0_low;
            assign p_quo[k]  = '0;
            assign p_dvs[k]  = r0_dvs;
            assign p_side[k] = r0_side;
        end else begin : g_next
            assign p_rem[k]  = r_rem[k-1];
            assign p_low[k]  = r_low[k-1];
            assign p_quo[k]  = r_quo[k-1];
            assign p_dvs[k]  = r_dvs[k-1];
            assign p_side[k] = r_side[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < QUO_W; k++) begin
            w_dv[k] = DRM_W'(p_dvs[k]);
            for (int i = 0; i < 3; i++) begin
                w_sh[k][i] = {p_rem[k][i], p_low[k][i][QUO_W-1]};
                w_ge[k][i] = (w_sh[k][i] >= w_dv[k]);
                n_rem[k][i] = w_ge[k][i] ? DVS_W'(w_sh[k][i] - w_dv[k])
                                         : DVS_W'(w_sh[k][i]);
                n_low[k][i] = p_low[k][i] << 1;
                n_quo[k][i] = {p_quo[k][i][QUO_W-2:0], w_ge[k][i]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QUO_W-2:0], r0_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QUO_W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_low[k]  <= n_low[k];
                r_quo[k]  <= n_quo[k];
                r_dvs[k]  <= p_dvs[k];
                r_side[k] <= p_side[k];
            end
        end
    end

    assign o_valid = r_v[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule
`default_nettype wire

// ===== sv/tetra_face_outward_normal.sv =====
`default_nettype none
// channel   valid     stall     payload   direction
// input     i_valid   o_stall   i_req     face vertices and opposite vertex
// output    o_valid   i_stall   o_rsp     outward unit normal and degenerate flag
//
// one face enters per cycle while o_stall is low; it passes the front stages,
// the 31-stage root, a prep stage, the 15-stage divide and the output register
// synchronous active-low reset clears all valid bits; data registers are not reset
// the whole pipeline holds while a result waits under i_stall, bubbles included
module tetra_face_outward_normal
    import tfon_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_rsp
);

    logic            r_o_valid;
    t_out            r_rsp;
    logic            w_en;
    logic [NPRE-1:0] r_pv;

    assign w_en    = !(r_o_valid && i_stall);
    assign o_stall = r_o_valid && i_stall;
    assign o_valid = r_o_valid;
    assign o_rsp   = r_rsp;

    // leading zeros of one byte group
    function automatic logic [GLZ_W-1:0] f_glz(input logic [GRP_W-1:0] v);
        logic [GLZ_W-1:0] n;
        n = '0;
        for (int b = 0; b < GRP_W; b++) begin
            if (v[b]) begin
                n = GLZ_W'(GRP_W - 1 - b);
            end
        end
        return n;
    endfunction

    // valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else if (w_en) begin
            r_pv <= {r_pv[NPRE-2:0], i_valid};
        end
    end

    // stage 1: edge and opposite differences
    logic signed [COORD_WIDTH-1:0] w_p0 [3];
    logic signed [COORD_WIDTH-1:0] w_p1 [3];
    logic signed [COORD_WIDTH-1:0] w_p2 [3];
    logic signed [COORD_WIDTH-1:0] w_p3 [3];
    logic signed [DIF_W-1:0]       r1_a [3];
    logic signed [DIF_W-1:0]       r1_b [3];
    logic signed [DIF_W-1:0]       r1_d [3];

    assign w_p0[0] = i_req.p0_x;
    assign w_p0[1] = i_req.p0_y;
    assign w_p0[2] = i_req.p0_z;
    assign w_p1[0] = i_req.p1_x;
    assign w_p1[1] = i_req.p1_y;
    assign w_p1[2] = i_req.p1_z;
    assign w_p2[0] = i_req.p2_x;
    assign w_p2[1] = i_req.p2_y;
    assign w_p2[2] = i_req.p2_z;
    assign w_p3[0] = i_req.opp_x;
    assign w_p3[1] = i_req.opp_y;
    assign w_p3[2] = i_req.opp_z;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_a[i] <= DIF_W'(w_p1[i]) - DIF_W'(w_p0[i]);
                r1_b[i] <= DIF_W'(w_p2[i]) - DIF_W'(w_p0[i]);
                r1_d[i] <= DIF_W'(w_p3[i]) - DIF_W'(w_p0[i]);
            end
        end
    end

    // stage 2: the six cross product terms
    logic signed [PRD_W-1:0] r2_pr [6];
    logic signed [DIF_W-1:0] r2_d  [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_pr[0] <= r1_a[1] * r1_b[2];
            r2_pr[1] <= r1_a[2] * r1_b[1];
            r2_pr[2] <= r1_a[2] * r1_b[0];
            r2_pr[3] <= r1_a[0] * r1_b[2];
            r2_pr[4] <= r1_a[0] * r1_b[1];
            r2_pr[5] <= r1_a[1] * r1_b[0];
            r2_d     <= r1_d;
        end
    end

    // stage 3: cross product
    logic signed [CRS_W-1:0] r3_c [3];
    logic signed [DIF_W-1:0] r3_d [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r3_c[i] <= CRS_W'(r2_pr[2*i]) - CRS_W'(r2_pr[2*i+1]);
            end
            r3_d <= r2_d;
        end
    end

    // stage 4: triple product partials, magnitudes, signs, zero test
    logic signed [PLO_W-1:0] r4_plo [3];
    logic signed [PHI_W-1:0] r4_phi [3];
    logic [CRS_W-1:0]        r4_mag [3];
    logic [2:0]              r4_sgn;
    logic                    r4_degen;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r4_plo[i] <= $signed({1'b0, r3_c[i][CLO_W-1:0]}) * r3_d[i];
                r4_phi[i] <= $signed(r3_c[i][CRS_W-1:CLO_W]) * r3_d[i];
                r4_mag[i] <= r3_c[i][CRS_W-1] ? CRS_W'(-r3_c[i]) : CRS_W'(r3_c[i]);
                r4_sgn[i] <= r3_c[i][CRS_W-1];
            end
            r4_degen <= (r3_c[0] == '0) && (r3_c[1] == '0) && (r3_c[2] == '0);
        end
    end

    // stage 5: partial sums, per-group leading zeros
    logic [PAD_W-1:0]        w_pad;
    logic [NGRP-1:0]         w_gnz;
    logic [GLZ_W-1:0]        w_glz [NGRP];
    logic signed [SLO_W-1:0] r5_slo;
    logic signed [SHI_W-1:0] r5_shi;
    logic [NGRP-1:0]         r5_gnz;
    logic [GLZ_W-1:0]        r5_glz [NGRP];
    logic [CRS_W-1:0]        r5_mag [3];
    logic [2:0]              r5_sgn;
    logic                    r5_degen;

    always_comb begin
        w_pad = PAD_W'(r4_mag[0] | r4_mag[1] | r4_mag[2]) << (PAD_W - CRS_W);
        for (int g = 0; g < NGRP; g++) begin
            w_gnz[g] = |w_pad[PAD_W-1-g*GRP_W -: GRP_W];
            w_glz[g] = f_glz(w_pad[PAD_W-1-g*GRP_W -: GRP_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_slo   <= SLO_W'(r4_plo[0]) + SLO_W'(r4_plo[1]) + SLO_W'(r4_plo[2]);
            r5_shi   <= SHI_W'(r4_phi[0]) + SHI_W'(r4_phi[1]) + SHI_W'(r4_phi[2]);
            r5_gnz   <= w_gnz;
            r5_glz   <= w_glz;
            r5_mag   <= r4_mag;
            r5_sgn   <= r4_sgn;
            r5_degen <= r4_degen;
        end
    end

    // stage 6: triple product sign, total leading zeros
    logic signed [TRP_W-1:0] w_t;
    logic [LZ_W-1:0]         w_lz;
    logic [LZ_W-1:0]         r6_lz;
    logic                    r6_flip;
    logic [CRS_W-1:0]        r6_mag [3];
    logic [2:0]              r6_sgn;
    logic                    r6_degen;

    assign w_t = (TRP_W'(r5_shi) <<< CLO_W) + TRP_W'(r5_slo);

    always_comb begin
        w_lz = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r5_gnz[g]) begin
                w_lz = LZ_W'(g * GRP_W) + LZ_W'(r5_glz[g]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_lz    <= w_lz;
            r6_flip  <= !w_t[TRP_W-1] && (w_t != '0);
            r6_mag   <= r5_mag;
            r6_sgn   <= r5_sgn;
            r6_degen <= r5_degen;
        end
    end

    // stage 7: common scaling so the largest magnitude fills MAG_W bits
    logic [CRS_W-1:0] w_nrm [3];
    t_mag3            r7_m;
    t_side            r7_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_nrm[i] = r6_mag[i] << r6_lz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r7_m[i] <= w_nrm[i][CRS_W-1 -: MAG_W];
            end
            r7_side.neg   <= r6_sgn ^ {3{r6_flip}};
            r7_side.degen <= r6_degen;
        end
    end

    // stage 8: squares
    logic [2*MAG_W-1:0] r8_sq [3];
    t_mag3              r8_m;
    t_side              r8_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r8_sq[i] <= r7_m[i] * r7_m[i];
            end
            r8_m    <= r7_m;
            r8_side <= r7_side;
        end
    end

    // stage 9: sum of squares
    logic [SUM_W-1:0] r9_sum;
    t_mag3            r9_m;
    t_side            r9_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_sum  <= SUM_W'(r8_sq[0]) + SUM_W'(r8_sq[1]) + SUM_W'(r8_sq[2]);
            r9_m    <= r8_m;
            r9_side <= r8_side;
        end
    end

    // length, then each component over it
    logic            w_sq_v;
    logic [RT_W-1:0] w_root;
    t_mag3           w_sq_m;
    t_side           w_sq_side;
    logic            w_dv_v;
    t_quo3           w_quo;
    t_side           w_dv_side;

    tfon_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_pv[NPRE-1]),
        .i_sum   (r9_sum),
        .i_mag   (r9_m),
        .i_side  (r9_side),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_mag   (w_sq_m),
        .o_side  (w_sq_side)
    );

    tfon_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_v),
        .i_root  (w_root),
        .i_mag   (w_sq_m),
        .i_side  (w_sq_side),
        .o_valid (w_dv_v),
        .o_quo   (w_quo),
        .o_side  (w_dv_side)
    );

    // output stage: saturate, apply sign, force zeros on a degenerate face
    logic [QUO_W-1:0]               w_sat [3];
    logic signed [NORMAL_WIDTH-1:0] w_cmp [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sat[i] = (w_quo[i] > NRM_LIM) ? NRM_LIM : w_quo[i];
            w_cmp[i] = w_dv_side.neg[i] ? -NORMAL_WIDTH'(w_sat[i])
                                        : NORMAL_WIDTH'(w_sat[i]);
            if (w_dv_side.degen) begin
                w_cmp[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rsp.normal_x   <= w_cmp[0];
            r_rsp.normal_y   <= w_cmp[1];
            r_rsp.normal_z   <= w_cmp[2];
            r_rsp.degenerate <= w_dv_side.degen;
        end
    end

`ifndef SYNTH
    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a degenerate face carries a zero normal
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.degenerate) |->
        (o_rsp.normal_x == '0 && o_rsp.normal_y == '0 && o_rsp.normal_z == '0))
        else $error("degenerate face with nonzero normal");

    // a proper face always has some nonzero component
    a_normal_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.degenerate) |->
        (o_rsp.normal_x != '0 || o_rsp.normal_y != '0 || o_rsp.normal_z != '0))
        else $error("zero normal on a proper face");
`endif

endmodule
`default_nettype wire

// ===== test/tetra_face_outward_normal_chk.sv =====
module tetra_face_outward_normal_chk
    import tfon_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_stall,
    input  t_in   i_req,
    input  logic  i_rsp_valid,
    input  logic  i_rsp_stall,
    input  t_out  i_rsp,
    output int    o_errors,
    output int    o_pending
);

    t_out normals_due[$];

    initial o_errors = 0;

    // outward unit normal of one face, exact integer arithmetic
    function automatic t_out face_normal(t_in f);
        logic signed [127:0] p0[3], a[3], b[3], d[3], c[3], t;
        logic [127:0] mg[3], orv;
        logic [63:0] m[3], s, r, bt, rem, v;
        logic [NORMAL_WIDTH-1:0] q[3];
        logic flip;
        int len;
        t_out o;
        p0[0] = f.p0_x; p0[1] = f.p0_y; p0[2] = f.p0_z;
        a[0] = f.p1_x;  a[1] = f.p1_y;  a[2] = f.p1_z;
        b[0] = f.p2_x;  b[1] = f.p2_y;  b[2] = f.p2_z;
        d[0] = f.opp_x; d[1] = f.opp_y; d[2] = f.opp_z;
        for (int i = 0; i < 3; i++) begin
            a[i] = a[i] - p0[i];
            b[i] = b[i] - p0[i];
            d[i] = d[i] - p0[i];
        end
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        o = '0;
        // zero cross product: flag only
        if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
            o.degenerate = 1'b1;
            return o;
        end
        t = c[0] * d[0] + c[1] * d[1] + c[2] * d[2];
        flip = (t > 0);
        orv = '0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = (c[i] < 0) ? -c[i] : c[i];
            orv |= mg[i];
        end
        len = 0;
        for (int i = 127; i >= 0; i--)
            if (orv[i] && len == 0) len = i + 1;
        // common scaling so the largest magnitude has 30 bits
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (len <= 30) ? 64'(mg[i] << (30 - len)) : 64'(mg[i] >> (len - 30));
            s += m[i] * m[i];
        end
        // integer square root
        rem = s;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > rem) bt >>= 2;
        while (bt != 0) begin
            if (rem >= r + bt) begin
                rem -= r + bt;
                r = (r >> 1) + bt;
            end else begin
                r >>= 1;
            end
            bt >>= 2;
        end
        // rounded divide, saturated, signed
        for (int i = 0; i < 3; i++) begin
            v = ((m[i] << (NORMAL_WIDTH - 1)) + r) / (2 * r);
            if (v > (64'd1 << (NORMAL_WIDTH - 2))) v = 64'd1 << (NORMAL_WIDTH - 2);
            q[i] = ((c[i] < 0) != flip) ? -v[NORMAL_WIDTH-1:0] : v[NORMAL_WIDTH-1:0];
        end
        o.normal_x = q[0];
        o.normal_y = q[1];
        o.normal_z = q[2];
        return o;
    endfunction

    task automatic report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        o_errors++;
    endtask

    // queue each taken request, compare each taken result
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_valid && !i_stall) normals_due.push_back(face_normal(i_req));
            if (i_rsp_valid && !i_rsp_stall) begin
                if (normals_due.size() == 0) begin
                    report("result with no request outstanding");
                end else begin
                    want = normals_due.pop_front();
                    if (i_rsp.normal_x !== want.normal_x)
                        report($sformatf("normal_x %0d want %0d", i_rsp.normal_x, want.normal_x));
                    if (i_rsp.normal_y !== want.normal_y)
                        report($sformatf("normal_y %0d want %0d", i_rsp.normal_y, want.normal_y));
                    if (i_rsp.normal_z !== want.normal_z)
                        report($sformatf("normal_z %0d want %0d", i_rsp.normal_z, want.normal_z));
                    if (i_rsp.degenerate !== want.degenerate)
                        report($sformatf("degenerate %0b want %0b", i_rsp.degenerate,
                                         want.degenerate));
                end
            end
            o_pending = normals_due.size();
        end
    end

endmodule

// ===== test/tetra_face_outward_normal_tb.sv =====
module tetra_face_outward_normal_tb
    import tfon_pkg::*;
;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_in  i_req = '0;
    logic o_stall;
    logic o_valid;
    t_out o_rsp;
    int   errors;
    int   pending;
    int   idle_pct = 0;
    int   stall_pct = 0;

    localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [COORD_WIDTH-1:0] ONE  = 1 <<< 16;

    tetra_face_outward_normal uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp)
    );

    tetra_face_outward_normal_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall(o_stall),
        .i_req(i_req), .i_rsp_valid(o_valid), .i_rsp_stall(i_stall), .i_rsp(o_rsp),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // run limit
    initial begin
        #3000000;
        $display("tetra_face_outward_normal_tb: errors");
        $finish;
    end

    function automatic logic signed [COORD_WIDTH-1:0] near(int span);
        return COORD_WIDTH'($urandom_range(2 * span) - span);
    endfunction

    // one request: random idle, then hold until taken
    task automatic send_face(t_in f);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= f;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_pts(logic signed [COORD_WIDTH-1:0] ax, ay, az, bx, by, bz,
                            cx, cy, cz, dx, dy, dz);
        send_face('{ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz});
    endtask

    // random face: full range, near range, degenerate or coplanar
    function automatic t_in random_face();
        t_in f;
        logic signed [COORD_WIDTH-1:0] ex, ey, ez;
        int k;
        k = $urandom_range(9);
        f = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom};
        if (k >= 4 && k <= 6) begin
            f.p1_x = f.p0_x + near(2000); f.p1_y = f.p0_y + near(2000);
            f.p1_z = f.p0_z + near(2000); f.p2_x = f.p0_x + near(2000);
            f.p2_y = f.p0_y + near(2000); f.p2_z = f.p0_z + near(2000);
            f.opp_x = f.p0_x + near(2000); f.opp_y = f.p0_y + near(2000);
            f.opp_z = f.p0_z + near(2000);
        end else if (k == 7) begin
            // collinear points
            ex = near(1000); ey = near(1000); ez = near(1000);
            f.p0_x = near(100000); f.p0_y = near(100000); f.p0_z = near(100000);
            f.p1_x = f.p0_x + ex; f.p1_y = f.p0_y + ey; f.p1_z = f.p0_z + ez;
            f.p2_x = f.p0_x - 3 * ex; f.p2_y = f.p0_y - 3 * ey; f.p2_z = f.p0_z - 3 * ez;
        end else if (k == 8) begin
            // opposite vertex in the face plane
            f.opp_x = f.p1_x; f.opp_y = f.p1_y; f.opp_z = f.p1_z;
        end
        return f;
    endfunction

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed faces
        send_pts(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pts(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
        send_pts(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE);
        send_pts(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, ONE, 0);
        send_pts(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX);
        send_pts(CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN);
        send_pts(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, 0, 0, 0);
        send_pts(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1);
        send_pts(0, 0, 0, 1, 1, 0, 1, 0, 1, CMAX, CMIN, CMAX);
        send_pts(0, 0, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 5, 6, 7);
        send_pts(5, 5, 5, 5, 5, 5, 5, 5, 5, 9, 9, 9);
        send_pts(1, 2, 3, 4, 5, 6, 7, 8, 10, 1, 2, 3);
        send_pts(0, 0, 0, ONE, ONE, 0, -ONE, ONE, 0, 3, 3, 0);
        send_pts(0, 0, 0, 3, 0, 0, 0, 4, 0, 0, 0, -1);
        send_pts(0, 0, 0, CMAX, 0, 0, 0, 1, 0, 0, 0, CMIN);
        send_pts(-1, -1, -1, CMAX, 1, 0, 1, CMAX, 0, 0, 0, 0);

        // random faces across idle and stall settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 54; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 54; end
                3: begin idle_pct = 12; stall_pct = 12; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            for (int n = 0; n < 280; n++) send_face(random_face());
        end
        i_valid <= 1'b0;

        // drain
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (errors == 0) begin
            $display("tetra_face_outward_normal_tb: clean");
        end else begin
            $display("tetra_face_outward_normal_tb: errors");
        end
        $finish;
    end

endmodule
